// File: hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  // Widest operand the unit is built for; fields are carried at this width
  localparam int unsigned MAX_W = 32;

  typedef enum logic [3:0] {
    ACT_NORM = 4'd0,
    ACT_ADD  = 4'd1,
    ACT_SUB  = 4'd2,
    ACT_MUL  = 4'd3,
    ACT_DIV  = 4'd4,
    ACT_GT   = 4'd5,
    ACT_LT   = 4'd6,
    ACT_EQ   = 4'd7,
    ACT_NE   = 4'd8,
    ACT_GE   = 4'd9,
    ACT_LE   = 4'd10
  } act_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_OVF  = 2'd2
  } stat_e;

  // One classified transaction as it waits in the queue
  typedef struct packed {
    act_e             act;
    logic             early;     // result known without arithmetic
    stat_e            early_st;
    logic             ln_neg;
    logic             ld_neg;
    logic             rn_neg;
    logic             rd_neg;
    logic [MAX_W-1:0] ln_mag;
    logic [MAX_W-1:0] ld_mag;
    logic [MAX_W-1:0] rn_mag;
    logic [MAX_W-1:0] rd_mag;
  } entry_t;

  // Queue status toward the back end
  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctl_t;

endpackage

`default_nettype wire

// File: hdl/rau_in_if.sv
// ----------------------------------------------------------------------------
// rau_in_if
// Operand channel: action and two fractions.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         action;
  logic signed [31:0] left_num;
  logic signed [31:0] left_den;
  logic signed [31:0] right_num;
  logic signed [31:0] right_den;

  modport source (output valid, action, left_num, left_den, right_num, right_den,
                  input ready);
  modport sink (input valid, action, left_num, left_den, right_num, right_den,
                output ready);
endinterface

`default_nettype wire

// File: hdl/rau_out_if.sv
// ----------------------------------------------------------------------------
// rau_out_if
// Result channel: reduced fraction, compare outcome and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic               cmp_true;
  logic [1:0]         status;

  modport source (output valid, res_num, res_den, cmp_true, status, input ready);
  modport sink (input valid, res_num, res_den, cmp_true, status, output ready);
endinterface

`default_nettype wire

// File: hdl/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front
// Accepts operand transactions, splits sign and magnitude, flags early cases.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  rau_in_if.sink          in_i,
  input  wire logic       full_i,
  output logic            push_o,
  output rau_pkg::entry_t entry_o
);

  logic [DATA_WIDTH-1:0] ln_v, ld_v, rn_v, rd_v;
  logic [DATA_WIDTH-1:0] ln_m, ld_m, rn_m, rd_m;

  // Take the low bits and form magnitudes
  assign ln_v = in_i.left_num[DATA_WIDTH-1:0];
  assign ld_v = in_i.left_den[DATA_WIDTH-1:0];
  assign rn_v = in_i.right_num[DATA_WIDTH-1:0];
  assign rd_v = in_i.right_den[DATA_WIDTH-1:0];
  assign ln_m = ln_v[DATA_WIDTH-1] ? (~ln_v + 1'b1) : ln_v;
  assign ld_m = ld_v[DATA_WIDTH-1] ? (~ld_v + 1'b1) : ld_v;
  assign rn_m = rn_v[DATA_WIDTH-1] ? (~rn_v + 1'b1) : rn_v;
  assign rd_m = rd_v[DATA_WIDTH-1] ? (~rd_v + 1'b1) : rd_v;

  // Classify the transaction
  always_comb begin
    entry_o          = '0;
    entry_o.act      = rau_pkg::act_e'(in_i.action);
    entry_o.ln_neg   = ln_v[DATA_WIDTH-1];
    entry_o.ld_neg   = ld_v[DATA_WIDTH-1];
    entry_o.rn_neg   = rn_v[DATA_WIDTH-1];
    entry_o.rd_neg   = rd_v[DATA_WIDTH-1];
    entry_o.ln_mag   = rau_pkg::MAX_W'(ln_m);
    entry_o.ld_mag   = rau_pkg::MAX_W'(ld_m);
    entry_o.rn_mag   = rau_pkg::MAX_W'(rn_m);
    entry_o.rd_mag   = rau_pkg::MAX_W'(rd_m);
    entry_o.early_st = rau_pkg::ST_OK;
    if (in_i.action > rau_pkg::ACT_LE) begin
      entry_o.early = 1'b1;
    end else if (ld_m == '0 ||
                 (in_i.action != rau_pkg::ACT_NORM && rd_m == '0)) begin
      entry_o.early    = 1'b1;
      entry_o.early_st = rau_pkg::ST_ZDEN;
    end
  end

  assign in_i.ready = ~full_i;
  assign push_o     = in_i.valid & ~full_i;

endmodule

`default_nettype wire

// File: hdl/rau_fifo.sv
// ----------------------------------------------------------------------------
// rau_fifo
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire rau_pkg::entry_t  entry_i,
  output logic                  full_o,
  output rau_pkg::q_ctl_t       ctl_o,
  input  wire logic             pop_i,
  output rau_pkg::entry_t       entry_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rau_pkg::entry_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign full_o      = (cnt_q == CNT_W'(DEPTH));
  assign ctl_o.valid = (cnt_q != '0);
  assign ctl_o.pop   = do_pop;
  assign do_pop      = pop_i & (cnt_q != '0);
  assign entry_o     = mem_q[rp_q];

  // Advance pointers and fill count
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_div #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] num_i,
  input  wire logic [W-1:0] den_i,
  output logic              done_o,
  output logic [W-1:0]      quo_o,
  output logic [W-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  quo_q, rem_q, den_q;
  logic [W-1:0]  quo_d, rem_d, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {rem_q, quo_q[W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  // Shift in one dividend bit and subtract when the divisor fits
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: hdl/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back
// Sequencer that reduces operands, multiplies, sums, compares and reduces
// results with a Euclid loop on a shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_back #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rau_pkg::q_ctl_t ctl_i,
  input  wire rau_pkg::entry_t entry_i,
  output logic                 pop_o,
  rau_out_if.source            out_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned PW = 2 * DATA_WIDTH;
  localparam logic [PW-1:0] LIMIT = PW'(1) << (DW - 1);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_AFTA   = 16'h0002,
    S_AFTB   = 16'h0004,
    S_ADDG   = 16'h0008,
    S_MULA   = 16'h0010,
    S_MULB   = 16'h0020,
    S_MULC   = 16'h0040,
    S_SUM    = 16'h0080,
    S_CMP    = 16'h0100,
    S_CHK    = 16'h0200,
    S_OUT    = 16'h0400,
    S_RSTART = 16'h0800,
    S_RGCD   = 16'h1000,
    S_RGWAIT = 16'h2000,
    S_RDIVN  = 16'h4000,
    S_RDIVD  = 16'h8000
  } state_e;

  state_e          st_q, st_d, ret_q, ret_d;
  rau_pkg::entry_t item_q, item_d;
  logic [DW-1:0]   an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [DW-1:0]   adp_q, adp_d, bdp_q, bdp_d;
  logic            a_neg_q, a_neg_d, b_neg_q, b_neg_d, r_neg_q, r_neg_d;
  logic [PW-1:0]   x_q, x_d, y_q, y_d, l_q, l_d;
  logic [PW-1:0]   u_q, u_d, v_q, v_d, ga_q, ga_d, gb_q, gb_d;
  logic [31:0]     pnum_q, pnum_d;
  logic [30:0]     pden_q, pden_d;
  logic            pcmp_q, pcmp_d;
  rau_pkg::stat_e  pst_q, pst_d;
  logic            ov_q, ov_d;
  logic [31:0]     onum_q, onum_d;
  logic [30:0]     oden_q, oden_d;
  logic            ocmp_q, ocmp_d;
  logic [1:0]      ost_q, ost_d;

  logic            div_start, div_done;
  logic [PW-1:0]   div_n, div_d, div_q, div_r;
  logic [DW-1:0]   mul_a, mul_b;
  logic [PW-1:0]   prod;
  logic            addsub, is_mul;
  logic            xs, ys, c_gt, c_lt, c_eq;
  logic            r_neg_eff, num_ok;
  logic signed [DW-1:0] snum;

  rau_div #(.W(PW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .done_o  (div_done),
    .quo_o   (div_q),
    .rem_o   (div_r)
  );

  assign addsub = (item_q.act == rau_pkg::ACT_ADD) || (item_q.act == rau_pkg::ACT_SUB);
  assign is_mul = (item_q.act == rau_pkg::ACT_MUL);

  // Select multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      S_MULA: begin
        mul_a = an_q;
        mul_b = addsub ? bdp_q : (is_mul ? bn_q : bd_q);
      end
      S_MULB: begin
        case (item_q.act)
          rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
            mul_a = bn_q;
            mul_b = adp_q;
          end
          rau_pkg::ACT_MUL: begin
            mul_a = ad_q;
            mul_b = bd_q;
          end
          rau_pkg::ACT_DIV: begin
            mul_a = ad_q;
            mul_b = bn_q;
          end
          default: begin
            mul_a = bn_q;
            mul_b = ad_q;
          end
        endcase
      end
      S_MULC: begin
        mul_a = adp_q;
        mul_b = bd_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // Exact compare of the cross products
  assign xs = a_neg_q & (x_q != '0);
  assign ys = b_neg_q & (y_q != '0);
  always_comb begin
    c_eq = 1'b0;
    c_gt = 1'b0;
    if (xs != ys) begin
      c_gt = ~xs;
    end else if (x_q == y_q) begin
      c_eq = 1'b1;
    end else if (xs) begin
      c_gt = (x_q < y_q);
    end else begin
      c_gt = (x_q > y_q);
    end
  end
  assign c_lt = ~c_gt & ~c_eq;

  // Range check of the reduced result
  assign r_neg_eff = r_neg_q & (u_q != '0);
  assign num_ok    = r_neg_eff ? (u_q <= LIMIT) : (u_q < LIMIT);
  assign snum      = r_neg_eff ? DW'(~u_q[DW-1:0] + 1'b1) : u_q[DW-1:0];

  // Sequence one transaction
  always_comb begin
    st_d      = st_q;
    ret_d     = ret_q;
    item_d    = item_q;
    an_d      = an_q;
    ad_d      = ad_q;
    bn_d      = bn_q;
    bd_d      = bd_q;
    adp_d     = adp_q;
    bdp_d     = bdp_q;
    a_neg_d   = a_neg_q;
    b_neg_d   = b_neg_q;
    r_neg_d   = r_neg_q;
    x_d       = x_q;
    y_d       = y_q;
    l_d       = l_q;
    u_d       = u_q;
    v_d       = v_q;
    ga_d      = ga_q;
    gb_d      = gb_q;
    pnum_d    = pnum_q;
    pden_d    = pden_q;
    pcmp_d    = pcmp_q;
    pst_d     = pst_q;
    ov_d      = ov_q & ~out_o.ready;
    onum_d    = onum_q;
    oden_d    = oden_q;
    ocmp_d    = ocmp_q;
    ost_d     = ost_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    case (st_q)
      S_IDLE: begin
        if (ctl_i.valid) begin
          pop_o  = 1'b1;
          item_d = entry_i;
          pnum_d = '0;
          pden_d = '0;
          pcmp_d = 1'b0;
          pst_d  = entry_i.early_st;
          if (entry_i.early) begin
            st_d = S_OUT;
          end else begin
            u_d   = PW'(entry_i.ln_mag[DW-1:0]);
            v_d   = PW'(entry_i.ld_mag[DW-1:0]);
            ret_d = S_AFTA;
            st_d  = S_RSTART;
          end
        end
      end
      S_AFTA: begin
        an_d    = u_q[DW-1:0];
        ad_d    = v_q[DW-1:0];
        a_neg_d = (item_q.ln_neg ^ item_q.ld_neg) & (u_q != '0);
        if (item_q.act == rau_pkg::ACT_NORM) begin
          r_neg_d = (item_q.ln_neg ^ item_q.ld_neg);
          st_d    = S_CHK;
        end else begin
          u_d   = PW'(item_q.rn_mag[DW-1:0]);
          v_d   = PW'(item_q.rd_mag[DW-1:0]);
          ret_d = S_AFTB;
          st_d  = S_RSTART;
        end
      end
      S_AFTB: begin
        bn_d    = u_q[DW-1:0];
        bd_d    = v_q[DW-1:0];
        b_neg_d = (item_q.rn_neg ^ item_q.rd_neg) & (u_q != '0);
        if (addsub) begin
          u_d   = PW'(ad_q);
          v_d   = v_q;
          ret_d = S_ADDG;
          st_d  = S_RSTART;
        end else if (item_q.act == rau_pkg::ACT_DIV && u_q == '0) begin
          pst_d = rau_pkg::ST_ZDEN;
          st_d  = S_OUT;
        end else begin
          st_d = S_MULA;
        end
      end
      S_ADDG: begin
        adp_d = u_q[DW-1:0];
        bdp_d = v_q[DW-1:0];
        st_d  = S_MULA;
      end
      S_MULA: begin
        x_d  = prod;
        st_d = S_MULB;
      end
      S_MULB: begin
        if (addsub) begin
          y_d  = prod;
          st_d = S_MULC;
        end else if (item_q.act >= rau_pkg::ACT_GT) begin
          y_d  = prod;
          st_d = S_CMP;
        end else begin
          l_d  = prod;
          st_d = S_SUM;
        end
      end
      S_MULC: begin
        l_d  = prod;
        st_d = S_SUM;
      end
      S_SUM: begin
        v_d   = l_q;
        ret_d = S_CHK;
        st_d  = S_RSTART;
        if (addsub) begin
          if (a_neg_q == (b_neg_q ^ (item_q.act == rau_pkg::ACT_SUB))) begin
            u_d     = x_q + y_q;
            r_neg_d = a_neg_q;
          end else if (x_q >= y_q) begin
            u_d     = x_q - y_q;
            r_neg_d = a_neg_q;
          end else begin
            u_d     = y_q - x_q;
            r_neg_d = ~a_neg_q;
          end
        end else begin
          u_d     = x_q;
          r_neg_d = a_neg_q ^ b_neg_q;
        end
      end
      S_CMP: begin
        case (item_q.act)
          rau_pkg::ACT_GT: pcmp_d = c_gt;
          rau_pkg::ACT_LT: pcmp_d = c_lt;
          rau_pkg::ACT_EQ: pcmp_d = c_eq;
          rau_pkg::ACT_NE: pcmp_d = ~c_eq;
          rau_pkg::ACT_GE: pcmp_d = ~c_lt;
          default:         pcmp_d = ~c_gt;
        endcase
        st_d = S_OUT;
      end
      S_CHK: begin
        if (num_ok && v_q < LIMIT) begin
          pnum_d = 32'(snum);
          pden_d = 31'(v_q[DW-2:0]);
        end else begin
          pst_d = rau_pkg::ST_OVF;
        end
        st_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || out_o.ready) begin
          ov_d   = 1'b1;
          onum_d = pnum_q;
          oden_d = pden_q;
          ocmp_d = pcmp_q;
          ost_d  = pst_q;
          st_d   = S_IDLE;
        end
      end
      S_RSTART: begin
        if (u_q == '0) begin
          v_d  = PW'(1);
          st_d = ret_q;
        end else begin
          ga_d = u_q;
          gb_d = v_q;
          st_d = S_RGCD;
        end
      end
      S_RGCD: begin
        div_start = 1'b1;
        if (gb_q == '0) begin
          div_n = u_q;
          div_d = ga_q;
          st_d  = S_RDIVN;
        end else begin
          div_n = ga_q;
          div_d = gb_q;
          st_d  = S_RGWAIT;
        end
      end
      S_RGWAIT: begin
        if (div_done) begin
          ga_d = gb_q;
          gb_d = div_r;
          st_d = S_RGCD;
        end
      end
      S_RDIVN: begin
        if (div_done) begin
          u_d       = div_q;
          div_start = 1'b1;
          div_n     = v_q;
          div_d     = ga_q;
          st_d      = S_RDIVD;
        end
      end
      S_RDIVD: begin
        if (div_done) begin
          v_d  = div_q;
          st_d = ret_q;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      ret_q <= S_IDLE;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      ret_q <= ret_d;
      ov_q  <= ov_d;
    end
  end

  // Hold datapath and result payload
  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    an_q    <= an_d;
    ad_q    <= ad_d;
    bn_q    <= bn_d;
    bd_q    <= bd_d;
    adp_q   <= adp_d;
    bdp_q   <= bdp_d;
    a_neg_q <= a_neg_d;
    b_neg_q <= b_neg_d;
    r_neg_q <= r_neg_d;
    x_q     <= x_d;
    y_q     <= y_d;
    l_q     <= l_d;
    u_q     <= u_d;
    v_q     <= v_d;
    ga_q    <= ga_d;
    gb_q    <= gb_d;
    pnum_q  <= pnum_d;
    pden_q  <= pden_d;
    pcmp_q  <= pcmp_d;
    pst_q   <= pst_d;
    onum_q  <= onum_d;
    oden_q  <= oden_d;
    ocmp_q  <= ocmp_d;
    ost_q   <= ost_d;
  end

  assign out_o.valid    = ov_q;
  assign out_o.res_num  = onum_q;
  assign out_o.res_den  = oden_q;
  assign out_o.cmp_true = ocmp_q;
  assign out_o.status   = ost_q;

endmodule

`default_nettype wire

// File: hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact fraction arithmetic and compare with results in lowest terms.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                          | handshake
//  in_i     | in  | action, left_num, left_den, right_num, right_den | valid/ready
//  out_o    | out | res_num, res_den, cmp_true, status               | valid/ready
//
//  Each reduction runs Euclid on one shared restoring divider of 2*DATA_WIDTH
//  bits: (k + 2) divisions, k the Euclid steps.
//  An item does up to four reductions.
//  A two-entry queue takes new transactions while the back end works or waits.
//  A finished result sits in the output register until it is taken.
//  Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);

  logic            push, full, pop;
  rau_pkg::entry_t f_entry, q_entry;
  rau_pkg::q_ctl_t q_ctl;

  rau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (f_entry)
  );

  rau_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .full_o  (full),
    .ctl_o   (q_ctl),
    .pop_i   (pop),
    .entry_o (q_entry)
  );

  rau_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (q_ctl),
    .entry_i (q_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
